// ----- rtl/fis_pkg.sv -----
// Package for the firing interlock sequencer.
// Holds payload structs, phase and state codes and register indexes.
// No dependencies.
package fis_pkg;

  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned PHASE_W   = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_LEAD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IGNITE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BURN   = 2'd2;

  // Configuration reset values.
  localparam logic [CFG_W-1:0] LEAD_RST   = 16'd250;
  localparam logic [CFG_W-1:0] IGNITE_RST = 16'd1000;
  localparam logic [CFG_W-1:0] BURN_RST   = 16'd5000;

  // Phase codes as seen on the result.
  localparam logic [PHASE_W-1:0] PHASE_IDLE   = 3'd0;
  localparam logic [PHASE_W-1:0] PHASE_LEAD   = 3'd1;
  localparam logic [PHASE_W-1:0] PHASE_IGNITE = 3'd2;
  localparam logic [PHASE_W-1:0] PHASE_BURN   = 3'd3;
  localparam logic [PHASE_W-1:0] PHASE_HALT   = 3'd4;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_LEAD   = 5'b00010,
    ST_IGNITE = 5'b00100,
    ST_BURN   = 5'b01000,
    ST_HALT   = 5'b10000
  } state_e;

  typedef struct packed {
    logic valve_arm_sw;
    logic igniter_arm_sw;
    logic valve_sw;
    logic igniter_sw;
    logic fire_sw;
  } in_item_t;

  typedef struct packed {
    logic               valve_open;
    logic               igniter_on;
    logic               valve_armed_lamp;
    logic               igniter_armed_lamp;
    logic               fire_armed_lamp;
    logic [PHASE_W-1:0] phase;
  } out_item_t;

  function automatic logic [PHASE_W-1:0] phase_code(state_e st);
    logic [PHASE_W-1:0] code;
    case (st)
      ST_IDLE:   code = PHASE_IDLE;
      ST_LEAD:   code = PHASE_LEAD;
      ST_IGNITE: code = PHASE_IGNITE;
      ST_BURN:   code = PHASE_BURN;
      default:   code = PHASE_HALT;
    endcase
    return code;
  endfunction

endpackage

// ----- rtl/fis_core.sv -----
// Sequencer core: configuration registers, interlock state and tick counter.
// Computes one result per accepted switch sample. Depends on fis_pkg.
module fis_core import fis_pkg::*; #(
  parameter int unsigned TICK_WIDTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 accept_i,
  input  in_item_t             item_i,
  output out_item_t            result_o
);

  localparam int unsigned CMP_W = (TICK_WIDTH > CFG_W) ? TICK_WIDTH : CFG_W;
  localparam logic [TICK_WIDTH-1:0] CNT_MAX = {TICK_WIDTH{1'b1}};

  logic [CFG_W-1:0] lead_q, ignite_q, burn_q;
  state_e           state_q, state_d;
  logic [TICK_WIDTH-1:0] cnt_q, cnt_d, cnt_inc;
  logic             valve_q, valve_d;
  logic             ign_q, ign_d;
  logic [2:0]       lamp_q, lamp_d;
  logic [CFG_W-1:0] limit;
  logic             expired;
  logic             fire_armed;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q   <= LEAD_RST;
      ignite_q <= IGNITE_RST;
      burn_q   <= BURN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LEAD:   lead_q   <= cfg_data_i;
        REG_IGNITE: ignite_q <= cfg_data_i;
        REG_BURN:   burn_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (state_q)
      ST_LEAD:   limit = lead_q;
      ST_IGNITE: limit = ignite_q;
      default:   limit = burn_q;
    endcase
  end

  // The counter saturates; reaching its top also ends the phase.
  assign cnt_inc = (cnt_q != CNT_MAX) ? cnt_q + 1'b1 : cnt_q;
  assign expired = (CMP_W'(cnt_inc) >= CMP_W'(limit)) || (cnt_inc == CNT_MAX);
  assign fire_armed = item_i.valve_arm_sw & item_i.igniter_arm_sw;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    valve_d = valve_q;
    ign_d   = ign_q;
    lamp_d  = lamp_q;
    case (state_q)
      ST_IDLE: begin
        lamp_d = {fire_armed, item_i.igniter_arm_sw, item_i.valve_arm_sw};
        if (fire_armed) begin
          if (item_i.fire_sw) begin
            valve_d = 1'b1;
            state_d = ST_LEAD;
            cnt_d   = '0;
          end else begin
            valve_d = 1'b0;
            ign_d   = 1'b0;
          end
        end else if (item_i.valve_arm_sw) begin
          valve_d = item_i.valve_sw;
        end else if (item_i.igniter_arm_sw) begin
          ign_d = item_i.igniter_sw;
        end
      end
      ST_LEAD: begin
        cnt_d = cnt_inc;
        if (expired) begin
          ign_d   = 1'b1;
          state_d = ST_IGNITE;
          cnt_d   = '0;
        end
      end
      ST_IGNITE: begin
        cnt_d = cnt_inc;
        if (expired) begin
          ign_d   = 1'b0;
          state_d = ST_BURN;
          cnt_d   = '0;
        end
      end
      ST_BURN: begin
        cnt_d = cnt_inc;
        if (expired || !item_i.fire_sw) begin
          valve_d = 1'b0;
          state_d = ST_HALT;
        end
      end
      default: begin
        valve_d = 1'b0;
        ign_d   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      valve_q <= 1'b0;
      ign_q   <= 1'b0;
      lamp_q  <= '0;
    end else if (accept_i) begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      valve_q <= valve_d;
      ign_q   <= ign_d;
      lamp_q  <= lamp_d;
    end
  end

  always_comb begin
    result_o.valve_open         = valve_d;
    result_o.igniter_on         = ign_d;
    result_o.valve_armed_lamp   = lamp_d[0];
    result_o.igniter_armed_lamp = lamp_d[1];
    result_o.fire_armed_lamp    = lamp_d[2];
    result_o.phase              = phase_code(state_d);
  end

endmodule

// ----- rtl/fis_out_buf.sv -----
// Two-entry output buffer that holds results until the consumer takes them.
// Lets a new sample in while a finished result still waits. Depends on fis_pkg.
module fis_out_buf import fis_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  out_item_t data_i,
  output logic      full_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  logic [1:0] cnt_q, cnt_d;
  out_item_t  head_q, tail_q;
  logic       pop;

  assign out_valid_o = (cnt_q != 2'd0);
  assign pop         = out_valid_o && !out_stall_i;
  assign out_data_o  = head_q;
  assign full_o      = (cnt_q == 2'd2);

  always_comb begin
    cnt_d = cnt_q;
    case ({push_i, pop})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // A push never arrives while full, so a simultaneous pop leaves one entry.
  always_ff @(posedge clk_i) begin
    case ({push_i, pop})
      2'b10: begin
        if (cnt_q == 2'd0) begin
          head_q <= data_i;
        end else begin
          tail_q <= data_i;
        end
      end
      2'b01: begin
        head_q <= tail_q;
      end
      2'b11: begin
        head_q <= data_i;
      end
      default: ;
    endcase
  end

endmodule

// ----- rtl/firing_interlock_sequencer_top.sv -----
// Each result is registered into the output buffer on its input transfer.
// Throughput: one switch sample per cycle until consumer stalls fill the
// two-entry output buffer; the state update is a single registered pass.
// Reset: asynchronous, active low; idle phase, outputs and lamps off, counter
// cleared, lead/ignite/burn back to 250/1000/5000 ticks, output buffer empty.
module firing_interlock_sequencer_top import fis_pkg::*; #(
  parameter int unsigned TICK_WIDTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_item_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_data_o
);

  logic      buf_full;
  out_item_t result;
  logic      accept;

  assign in_stall_o = buf_full;
  assign accept     = in_valid_i && !buf_full;

  fis_core #(
    .TICK_WIDTH(TICK_WIDTH)
  ) u_core (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .accept_i (accept),
    .item_i   (in_data_i),
    .result_o (result)
  );

  fis_out_buf u_out_buf (
    .clk_i,
    .rst_ni,
    .push_i      (accept),
    .data_i      (result),
    .full_o      (buf_full),
    .out_valid_o,
    .out_stall_i,
    .out_data_o
  );

endmodule

// ----- rtl/fis_checker.sv -----
// Port-level checks for the firing interlock sequencer, bound to the top level.
// Depends on fis_pkg.
module fis_checker import fis_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_data_o
);

  // A stalled result stays on the port unchanged.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or dropped");

  // Input stall only comes from a full buffer, which has data to show.
  a_stall_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no pending result");

  // Once halted, valves and igniter are closed.
  a_halt_safe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.phase == PHASE_HALT)
      |-> !out_data_o.valve_open && !out_data_o.igniter_on)
    else $error("outputs active while halted");

  // During the lead and ignite phases the valves are open.
  a_valve_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.phase == PHASE_LEAD || out_data_o.phase == PHASE_IGNITE)
      |-> out_data_o.valve_open)
    else $error("valves closed during firing sequence");

  // The igniter never drives in the burn or halt phases. It may still be on in
  // the lead phase when a manual igniter command was left on before the start.
  a_ign_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.igniter_on
      |-> (out_data_o.phase != PHASE_BURN && out_data_o.phase != PHASE_HALT))
    else $error("igniter on in burn or halt phase");

endmodule

bind firing_interlock_sequencer_top fis_checker u_fis_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
